@@ rtl/btpc_pkg.sv @@
// shared types, constants and 64-bit multiply helpers for the compensation block
// no dependencies
`default_nettype none

package btpc_pkg;

    // compensation constants
    localparam logic [63:0] C_FINE_OFFS = 64'd128000;
    localparam logic [20:0] C_P_BASE    = 21'd1048576;
    localparam logic [63:0] C_NUM_MUL   = 64'd3125;
    localparam logic [31:0] C_T_MUL     = 32'd5;
    localparam logic [31:0] C_T_ROUND   = 32'd128;
    localparam logic [63:0] C_DEN_BIAS  = 64'h0000_8000_0000_0000;

    // register indexes of the configuration port
    localparam logic [2:0] C_REG_TEMP_CAL  = 3'd0;
    localparam logic [2:0] C_REG_PRESS_LO  = 3'd1;
    localparam logic [2:0] C_REG_PRESS_HI  = 3'd2;
    localparam logic [2:0] C_REG_PRESS_P9  = 3'd3;

    localparam int unsigned C_DIV_W = 64;

    // partial products of a 64x64 multiply, low 64 bits kept
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pp;

    // one divider stage
    typedef struct packed {
        logic        vld;
        logic        err;
        logic        neg;
        logic [31:0] temp;
        logic [63:0] rem;
        logic [63:0] dq;
        logic [63:0] ub;
    } t_dv;

    // three 32x32 partial products
    function automatic t_pp pp_mul(input logic [63:0] x, input logic [63:0] y);
        t_pp r;
        r.ll = x[31:0] * y[31:0];
        r.lh = 32'(x[31:0] * y[63:32]);
        r.hl = 32'(x[63:32] * y[31:0]);
        return r;
    endfunction

    // combine partial products, modulo 2^64
    function automatic logic [63:0] pp_sum(input t_pp p);
        return p.ll + {p.lh + p.hl, 32'h0};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] s);
        return 64'($signed(v) >>> s);
    endfunction

endpackage

`default_nettype wire

@@ rtl/btpc_div.sv @@
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
// depends on btpc_pkg
`default_nettype none

module btpc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic        i_err,
    input  wire logic [31:0] i_temp,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_vld,
    output logic             o_err,
    output logic [31:0]      o_temp,
    output logic [63:0]      o_quo
);
    import btpc_pkg::*;

    btpc_pkg::t_dv r_st [0:C_DIV_W];
    btpc_pkg::t_dv n_st [0:C_DIV_W];
    logic          r_vld;
    logic          r_err;
    logic [31:0]   r_temp;
    logic [63:0]   r_quo;

    // setup: magnitudes and result sign
    always_comb begin
        n_st[0].vld  = i_vld;
        n_st[0].err  = i_err;
        n_st[0].neg  = i_num[63] ^ i_den[63];
        n_st[0].temp = i_temp;
        n_st[0].rem  = '0;
        n_st[0].dq   = i_num[63] ? (64'd0 - i_num) : i_num;
        n_st[0].ub   = i_den[63] ? (64'd0 - i_den) : i_den;
    end

    // restoring steps, one per stage
    for (genvar k = 1; k <= C_DIV_W; k++) begin : g_step
        logic [63:0] sh;
        logic        ge;
        always_comb begin
            sh = {r_st[k-1].rem[62:0], r_st[k-1].dq[63]};
            ge = (sh >= r_st[k-1].ub);
            n_st[k]     = r_st[k-1];
            n_st[k].rem = ge ? (sh - r_st[k-1].ub) : sh;
            n_st[k].dq  = {r_st[k-1].dq[62:0], ge};
        end
    end

    // stage registers
    for (genvar k = 0; k <= C_DIV_W; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].vld <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // apply sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld  <= r_st[C_DIV_W].vld;
            r_err  <= r_st[C_DIV_W].err;
            r_temp <= r_st[C_DIV_W].temp;
            r_quo  <= r_st[C_DIV_W].neg ? (64'd0 - r_st[C_DIV_W].dq) : r_st[C_DIV_W].dq;
        end
    end

    assign o_vld  = r_vld;
    assign o_err  = r_err;
    assign o_temp = r_temp;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ rtl/baro_temp_pressure_compensation.sv @@
// barometric temperature and pressure compensation, top level
// depends on btpc_pkg and btpc_div
//
// usage:
//   write the four calibration registers through i_cfg_we / i_cfg_idx / i_cfg_data
//   while the block is idle; index 0 temperature words, 1 and 2 pressure words,
//   3 coefficient P9; other indexes are ignored
//   input channel i_in_valid / o_in_ready carries raw temperature and pressure
//   output channel o_out_valid / i_out_ready carries temperature in 0.01 degC,
//   pressure in Pa as Q24.8 and the divide error flag
// throughput: one word per cycle unless stalled, every stage is registered
// pipeline: 12 stages of temperature and product terms,
//   66 in the one-bit-per-stage divider, 6 for the final terms
// reset: all valid bits clear, calibration registers read zero
// stall: when a result waits and i_out_ready is low the whole pipeline holds,
//   o_in_ready drops and nothing is lost or repeated
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [19:0] i_raw_temperature,
    input  wire logic [19:0] i_raw_pressure,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [31:0] o_temperature_centideg,
    output logic [31:0]      o_pressure_q24_8,
    output logic             o_divide_error
);
    import btpc_pkg::*;

    // calibration registers
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_press_lo <= '0;
            r_press_hi <= '0;
            r_press_p9 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_TEMP_CAL: r_temp_cal <= i_cfg_data[47:0];
                C_REG_PRESS_LO: r_press_lo <= i_cfg_data;
                C_REG_PRESS_HI: r_press_hi <= i_cfg_data;
                C_REG_PRESS_P9: r_press_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0] t1;
    logic signed [15:0] t2, t3;
    assign t1 = r_temp_cal[15:0];
    assign t2 = r_temp_cal[31:16];
    assign t3 = r_temp_cal[47:32];

    logic r_vld [1:12];
    logic r_out_vld;

    // global advance: hold everything while a result waits
    logic en;
    assign en = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // stage 1: differences of raw temperature and T1, and of the pressure base and raw pressure
    logic signed [31:0] r1_ta, r1_td;
    logic [20:0]        r1_p;
    // stage 2: first products
    logic signed [31:0] r2_am, r2_dd;
    // stage 3
    logic signed [31:0] r3_a, r3_b;
    // stage 4: fine term
    logic signed [31:0] r4_fine;
    // stage 5 onward
    logic [63:0]        r5_a;
    logic [31:0]        r_temp [5:12];
    logic [20:0]        r_p [2:9];
    t_pp                r6_aa, r6_ap5, r6_ap2;
    logic [63:0]        r7_aa, r7_ap5, r7_ap2;
    t_pp                r8_aap6, r8_aap3;
    logic [63:0]        r8_ap5, r8_ap2;
    logic [63:0]        r9_b, r9_a2;
    logic [63:0]        r10_x, r10_n0;
    t_pp                r11_den, r11_num;
    logic [63:0]        r12_den, r12_num;

    logic signed [31:0] s5_t;
    assign s5_t = r4_fine * $signed(C_T_MUL) + $signed(C_T_ROUND);

    // front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 12; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_in_valid;
            for (int k = 2; k <= 12; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // temperature, 32-bit wrap
            r1_ta <= 32'(i_raw_temperature[19:3]) - 32'({t1, 1'b0});
            r1_td <= 32'(i_raw_temperature[19:4]) - 32'(t1);
            r1_p  <= C_P_BASE - {1'b0, i_raw_pressure};
            r2_am <= r1_ta * t2;
            r2_dd <= r1_td * r1_td;
            r3_a  <= r2_am >>> 11;
            r3_b  <= (r2_dd >>> 12) * t3;
            r4_fine <= r3_a + (r3_b >>> 14);
            r_temp[5] <= 32'(s5_t >>> 8);
            r5_a <= {{32{r4_fine[31]}}, r4_fine} - C_FINE_OFFS;
            for (int k = 6; k <= 12; k++) r_temp[k] <= r_temp[k-1];
            r_p[2] <= r1_p;
            for (int k = 3; k <= 9; k++) r_p[k] <= r_p[k-1];
            // pressure terms, 64-bit wrap
            r6_aa  <= pp_mul(r5_a, r5_a);
            r6_ap5 <= pp_mul(r5_a, sx16(r_press_hi[15:0]));
            r6_ap2 <= pp_mul(r5_a, sx16(r_press_lo[31:16]));
            r7_aa  <= pp_sum(r6_aa);
            r7_ap5 <= pp_sum(r6_ap5);
            r7_ap2 <= pp_sum(r6_ap2);
            r8_aap6 <= pp_mul(r7_aa, sx16(r_press_hi[31:16]));
            r8_aap3 <= pp_mul(r7_aa, sx16(r_press_lo[47:32]));
            r8_ap5  <= r7_ap5;
            r8_ap2  <= r7_ap2;
            r9_b  <= pp_sum(r8_aap6) + (r8_ap5 << 17) + (sx16(r_press_lo[63:48]) << 35);
            r9_a2 <= asr64(pp_sum(r8_aap3), 6'd8) + (r8_ap2 << 12);
            r10_x  <= C_DEN_BIAS + r9_a2;
            r10_n0 <= ({43'd0, r_p[9]} << 31) - r9_b;
            r11_den <= pp_mul(r10_x, {48'd0, r_press_lo[15:0]});
            r11_num <= pp_mul(r10_n0, C_NUM_MUL);
            r12_den <= asr64(pp_sum(r11_den), 6'd33);
            r12_num <= pp_sum(r11_num);
        end
    end

    // division
    logic        dv_vld, dv_err;
    logic [31:0] dv_temp;
    logic [63:0] dv_quo;

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[12]),
        .i_err   (r12_den == 64'd0),
        .i_temp  (r_temp[12]),
        .i_num   (r12_num),
        .i_den   (r12_den),
        .o_vld   (dv_vld),
        .o_err   (dv_err),
        .o_temp  (dv_temp),
        .o_quo   (dv_quo)
    );

    // back stages: P9 and P8 corrections
    logic        r_pv  [2:6];
    logic        r_perr[2:6];
    logic [31:0] r_ptmp[2:6];
    logic [63:0] r_q   [2:5];
    t_pp         r2p_m, r2p_b8, r4p_mps;
    logic [63:0] r3p_m, r3p_b8, r4p_b8, r5p_b8, r5p_a3, r6p_s;
    logic [31:0] r_press;
    logic [31:0] r_otemp;
    logic        r_oerr;
    logic [63:0] n_press;

    assign n_press = asr64(r6p_s, 6'd8) + (sx16(r_press_hi[47:32]) << 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 2; k <= 6; k++) r_pv[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_pv[2] <= dv_vld;
            for (int k = 3; k <= 6; k++) r_pv[k] <= r_pv[k-1];
            r_out_vld <= r_pv[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_perr[2] <= dv_err;
            r_ptmp[2] <= dv_temp;
            r_q[2]    <= dv_quo;
            for (int k = 3; k <= 6; k++) begin
                r_perr[k] <= r_perr[k-1];
                r_ptmp[k] <= r_ptmp[k-1];
            end
            for (int k = 3; k <= 5; k++) r_q[k] <= r_q[k-1];
            r2p_m  <= pp_mul(sx16(r_press_p9), asr64(dv_quo, 6'd13));
            r2p_b8 <= pp_mul(sx16(r_press_hi[63:48]), dv_quo);
            r3p_m  <= pp_sum(r2p_m);
            r3p_b8 <= pp_sum(r2p_b8);
            r4p_mps <= pp_mul(r3p_m, asr64(r_q[3], 6'd13));
            r4p_b8  <= r3p_b8;
            r5p_a3  <= asr64(pp_sum(r4p_mps), 6'd25);
            r5p_b8  <= r4p_b8;
            r6p_s   <= r_q[5] + r5p_a3 + asr64(r5p_b8, 6'd19);
            r_press <= r_perr[6] ? 32'd0 : n_press[31:0];
            r_otemp <= r_ptmp[6];
            r_oerr  <= r_perr[6];
        end
    end

    assign o_out_valid            = r_out_vld;
    assign o_temperature_centideg = $signed(r_otemp);
    assign o_pressure_q24_8       = r_press;
    assign o_divide_error         = r_oerr;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench for baro_temp_pressure_compensation: predicts each compensated word and checks it
// depends on btpc_pkg and the compensation rtl
`timescale 1ns / 1ps

module testbench;
    import btpc_pkg::*;

    typedef struct {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic               err;
    } t_comp_word;

    // holds the calibration copy and the queue of predicted words
    class comp_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_p9;
        t_comp_word  pending[$];
        int          mismatches;

        function new();
            temp_cal = '0;
            press_lo = '0;
            press_hi = '0;
            press_p9 = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                C_REG_TEMP_CAL: temp_cal = val[47:0];
                C_REG_PRESS_LO: press_lo = val;
                C_REG_PRESS_HI: press_hi = val;
                C_REG_PRESS_P9: press_p9 = val[15:0];
                default: ;
            endcase
        endfunction

        // compensation arithmetic, wrapping at 32 bits for temperature and 64 for pressure
        function t_comp_word compensate(logic [19:0] adc_t, logic [19:0] adc_p);
            t_comp_word         r;
            logic signed [31:0] t1, t2, t3, x, y, d, fine;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] a, b, den, num, q, pv, aa;
            logic [63:0]        ua, ub, uq;
            logic               neg;
            t1 = {16'd0, temp_cal[15:0]};
            t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
            t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
            x = ({12'd0, adc_t} >> 3) - (t1 << 1);
            x = (x * t2) >>> 11;
            d = ({12'd0, adc_t} >> 4) - t1;
            y = (d * d) >>> 12;
            y = (y * t3) >>> 14;
            fine = x + y;
            r.temp = (fine * 32'sd5 + 32'sd128) >>> 8;
            p1 = {48'd0, press_lo[15:0]};
            p2 = {{48{press_lo[31]}}, press_lo[31:16]};
            p3 = {{48{press_lo[47]}}, press_lo[47:32]};
            p4 = {{48{press_lo[63]}}, press_lo[63:48]};
            p5 = {{48{press_hi[15]}}, press_hi[15:0]};
            p6 = {{48{press_hi[31]}}, press_hi[31:16]};
            p7 = {{48{press_hi[47]}}, press_hi[47:32]};
            p8 = {{48{press_hi[63]}}, press_hi[63:48]};
            p9 = {{48{press_p9[15]}}, press_p9};
            a = 64'(fine) - 64'sd128000;
            b = a * a * p6;
            b = b + ((a * p5) <<< 17);
            b = b + (p4 <<< 35);
            aa = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
            den = (((64'sd1 <<< 47) + aa) * p1) >>> 33;
            r.press = '0;
            r.err = 1'b0;
            if (den == 0) begin
                r.err = 1'b1;
            end else begin
                pv = 64'sd1048576 - 64'(adc_p);
                num = ((pv <<< 31) - b) * 64'sd3125;
                neg = num[63] ^ den[63];
                ua = num[63] ? -num : num;
                ub = den[63] ? -den : den;
                uq = ua / ub;
                q = neg ? -uq : uq;
                a = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
                b = (p8 * q) >>> 19;
                pv = ((q + a + b) >>> 8) + (p7 <<< 4);
                r.press = pv[31:0];
            end
            return r;
        endfunction

        function void note_input(logic [19:0] adc_t, logic [19:0] adc_p);
            pending.push_back(compensate(adc_t, adc_p));
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_word(logic signed [31:0] temp, logic [31:0] press, logic err);
            t_comp_word e;
            if (pending.size() == 0) begin
                report("word with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (temp !== e.temp)
                report($sformatf("temperature got %0d want %0d", temp, e.temp));
            if (press !== e.press)
                report($sformatf("pressure got %h want %h", press, e.press));
            if (err !== e.err)
                report($sformatf("divide error got %b want %b", err, e.err));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] temp_out;
    logic [31:0] press_out;
    logic        err_out;

    comp_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  quiet_cycles;

    localparam int LATENCY     = 84;
    localparam int QUIET_LIMIT = 4000;

    baro_temp_pressure_compensation u_top (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_idx              (cfg_idx),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .o_in_ready             (in_ready),
        .i_raw_temperature      (raw_t),
        .i_raw_pressure         (raw_p),
        .o_out_valid            (out_valid),
        .i_out_ready            (out_ready),
        .o_temperature_centideg (temp_out),
        .o_pressure_q24_8       (press_out),
        .o_divide_error         (err_out)
    );

    // clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (!rst_n || hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // check each accepted result word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(temp_out, press_out, err_out);
    end

    // watchdog on cycles with no accepted word and no register write
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // valid stays high into the next word unless a random idle drops it; drain drops it at the end
    task automatic send_word(logic [19:0] t, logic [19:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_t <= t;
        raw_p <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(t, p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // one calibration set; mode picks typical, zero, all ones, extreme values or random
    task automatic load_cal(int mode);
        logic [63:0] w0, w1, w2, w3;
        case (mode)
            0: begin
                // typical factory words
                w0 = 64'({16'hFC18, 16'h6810, 16'h6E88});
                w1 = {16'h2011, 16'hF00C, 16'hD5C7, 16'h8E62};
                w2 = {16'hEA0B, 16'h0F28, 16'hFFF9, 16'h0087};
                w3 = 64'h1770;
            end
            1: begin
                w0 = '0; w1 = '0; w2 = '0; w3 = '0;
            end
            2: begin
                w0 = '1; w1 = '1; w2 = '1; w3 = '1;
            end
            3: begin
                w0 = 64'({16'h8000, 16'h7FFF, 16'hFFFF});
                w1 = {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
                w2 = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
                w3 = 64'h8000;
            end
            default: begin
                w0 = {$urandom, $urandom};
                w1 = {$urandom, $urandom};
                w2 = {$urandom, $urandom};
                w3 = {$urandom, $urandom};
            end
        endcase
        write_reg(C_REG_TEMP_CAL, w0);
        write_reg(C_REG_PRESS_LO, w1);
        write_reg(C_REG_PRESS_HI, w2);
        write_reg(C_REG_PRESS_P9, w3);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(int n, int mode);
        logic [19:0] t, p;
        for (int i = 0; i < n; i++) begin
            t = 20'($urandom);
            p = 20'($urandom);
            // in mode 0, mostly sensor-like readings around the usual operating point
            if (mode == 0 && $urandom_range(3) != 0) begin
                t = 20'($urandom_range(400000, 600000));
                p = 20'($urandom_range(250000, 450000));
            end
            send_word(t, p);
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        raw_t = '0;
        raw_p = '0;
        send_idle_pct = 14;
        recv_idle_pct = 56;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset calibration: all zero divisor
        send_word(20'd519888, 20'd415148);
        drain();
        // an out-of-range index must be ignored
        write_reg(3'd7, '1);
        load_cal(0);
        send_word(20'd0, 20'd0);
        send_word(20'hFFFFF, 20'hFFFFF);
        send_word(20'd0, 20'hFFFFF);
        send_word(20'hFFFFF, 20'd0);
        send_word(20'd519888, 20'd415148);
        send_word(20'h55555, 20'hAAAAA);
        send_word(20'hAAAAA, 20'h55555);
        drain();
        for (int m = 1; m <= 3; m++) begin
            load_cal(m);
            send_word(20'd0, 20'd0);
            send_word(20'hFFFFF, 20'hFFFFF);
            send_word(20'd519888, 20'd415148);
            send_word(20'hAAAAA, 20'h55555);
            drain();
        end
        // phase 1: sender idles little, receiver a lot
        load_cal(0);
        random_items(250, 0);
        drain();
        load_cal(4);
        random_items(100, 1);
        drain();
        // phase 2: roles swapped, with a long receiver hold-off
        send_idle_pct = 56;
        recv_idle_pct = 14;
        load_cal(0);
        fork
            random_items(300, 0);
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain();
        // phase 3: no idling at all
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_cal(4);
        random_items(200, 1);
        drain();
        load_cal(0);
        random_items(250, 0);
        drain();
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
